/* hw/rtl/vap_pkg.sv */
// vap_pkg: shared types and constants for the vertex attribute layout packer.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package vap_pkg;

  // Component type codes
  localparam logic [2:0] TYPE_I8     = 3'd0;
  localparam logic [2:0] TYPE_U8     = 3'd1;
  localparam logic [2:0] TYPE_I16    = 3'd2;
  localparam logic [2:0] TYPE_U16    = 3'd3;
  localparam logic [2:0] TYPE_I32    = 3'd4;
  localparam logic [2:0] TYPE_U32    = 3'd5;
  localparam logic [2:0] TYPE_F32    = 3'd6;
  localparam logic [2:0] TYPE_PACKED = 3'd7;

  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned BYTES_W = 7;
  localparam int unsigned ALIGN_W = 3;

  localparam logic [BYTES_W-1:0] PACKED_BYTES = 7'd4;
  localparam logic [ALIGN_W-1:0] WIDE_ALIGN   = 3'd4;
  localparam logic [ALIGN_W-1:0] UNIT_ALIGN   = 3'd1;
  localparam logic [COUNT_W-1:0] TRIPLE_COUNT = 5'd3;

  // log2 of the component size in bytes (sizes 1,1,2,2,4,4,4,4)
  function automatic logic [1:0] comp_shift(input logic [TYPE_W-1:0] ctype);
    logic [1:0] sh;
    case (ctype)
      TYPE_I8, TYPE_U8:   sh = 2'd0;
      TYPE_I16, TYPE_U16: sh = 2'd1;
      default:            sh = 2'd2;
    endcase
    return sh;
  endfunction

  function automatic logic count_ok(input logic [COUNT_W-1:0] cnt);
    return ((cnt >= 5'd1) && (cnt <= 5'd4)) || (cnt == 5'd8) ||
           (cnt == 5'd12) || (cnt == 5'd16);
  endfunction

endpackage

/* hw/rtl/vap_if.sv */
// vap_if: valid/ready channel interfaces for attribute items and layout results.
// Depends on vap_pkg for field widths.
`timescale 1ns / 1ps

interface vap_attr_if;
  import vap_pkg::*;
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  component_type;
  logic [COUNT_W-1:0] component_count;
  logic               final_attribute;

  modport source (output valid, component_type, component_count, final_attribute,
                  input ready);
  modport sink   (input valid, component_type, component_count, final_attribute,
                  output ready);
endinterface

interface vap_res_if #(
  parameter int unsigned OFFSET_BITS = 11
);
  import vap_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] attribute_offset;
  logic [BYTES_W-1:0]     attribute_bytes;
  logic [OFFSET_BITS-1:0] vertex_stride;
  logic                   layout_done;
  logic                   bad_count;

  modport source (output valid, attribute_offset, attribute_bytes, vertex_stride,
                  layout_done, bad_count, input ready);
  modport sink   (input valid, attribute_offset, attribute_bytes, vertex_stride,
                  layout_done, bad_count, output ready);
endinterface

/* hw/rtl/vertex_attribute_layout_packer.sv */
// vertex_attribute_layout_packer: places vertex attributes at aligned offsets
// and gives the padded stride. Depends on vap_pkg and the channels in vap_if.
`timescale 1ns / 1ps

//  channel   dir   payload
//  attr_i    in    component_type, component_count, final_attribute
//  res_o     out   attribute_offset, attribute_bytes, vertex_stride,
//                  layout_done, bad_count
//
// One attribute per cycle unless res_o stalls, via input and result registers.
// Placement and layout state update in one pass when an item leaves the input
// register. Reset clears both stages and starts a new format at offset 0.
// A stalled result holds; the input register keeps filling until both are full.

module vertex_attribute_layout_packer #(
  parameter int unsigned OFFSET_BITS = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vap_attr_if.sink      attr_i,
  vap_res_if.source     res_o
);
  import vap_pkg::*;

  localparam int unsigned OW = OFFSET_BITS;
  localparam logic [OW-1:0] OMAX = {OW{1'b1}};

  // input register
  logic               in_vld_q;
  logic [TYPE_W-1:0]  in_type_q;
  logic [COUNT_W-1:0] in_count_q;
  logic               in_final_q;

  // result register
  logic               out_vld_q;
  logic [OW-1:0]      out_offset_q, out_offset_d;
  logic [BYTES_W-1:0] out_bytes_q, out_bytes_d;
  logic [OW-1:0]      out_stride_q, out_stride_d;
  logic               out_done_q;
  logic               out_bad_q, out_bad_d;

  // layout state
  logic [OW-1:0]      run_off_q, run_off_d;
  logic [ALIGN_W-1:0] first_align_q, first_align_d;
  logic               expect_first_q, expect_first_d;

  logic out_load;
  logic in_load;

  assign out_load    = in_vld_q && (!out_vld_q || res_o.ready);
  assign in_load     = attr_i.valid && attr_i.ready;
  assign attr_i.ready = !in_vld_q || out_load;

  // padding helpers
  function automatic logic [OW-1:0] sat_add(input logic [OW-1:0] a,
                                            input logic [OW-1:0] b);
    logic [OW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OW] ? OMAX : s[OW-1:0];
  endfunction

  function automatic logic [OW-1:0] pad_up(input logic [OW-1:0] off,
                                           input logic [ALIGN_W-1:0] align);
    logic [OW-1:0] m;
    m = {{(OW-ALIGN_W){1'b0}}, align - UNIT_ALIGN};
    return sat_add(off, m) & ~m;
  endfunction

  logic [1:0]         csh;
  logic [ALIGN_W-1:0] align;
  logic [ALIGN_W-1:0] stride_align;
  logic [OW-1:0]      end_off;

  always_comb begin
    csh = comp_shift(in_type_q);
    if (in_type_q == TYPE_PACKED) begin
      out_bytes_d = PACKED_BYTES;
      align       = WIDE_ALIGN;
    end else begin
      out_bytes_d = {2'b00, in_count_q} << csh;
      // three small components are aligned to a word boundary
      align = ((in_count_q == TRIPLE_COUNT) && (csh != 2'd2)) ? WIDE_ALIGN
                                                                : (UNIT_ALIGN << csh);
    end
    out_bad_d = !count_ok(in_count_q);

    if (expect_first_q) begin
      out_offset_d  = '0;
      stride_align  = align;
    end else begin
      out_offset_d  = pad_up(run_off_q, align);
      stride_align  = first_align_q;
    end
    end_off = sat_add(out_offset_d, {{(OW-BYTES_W){1'b0}}, out_bytes_d});

    if (in_final_q) begin
      out_stride_d   = pad_up(end_off, stride_align);
      run_off_d      = '0;
      first_align_d  = UNIT_ALIGN;
      expect_first_d = 1'b1;
    end else begin
      out_stride_d   = '0;
      run_off_d      = end_off;
      first_align_d  = stride_align;
      expect_first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      run_off_q      <= '0;
      first_align_q  <= UNIT_ALIGN;
      expect_first_q <= 1'b1;
    end else begin
      if (in_load) begin
        in_vld_q <= 1'b1;
      end else if (out_load) begin
        in_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q      <= 1'b1;
        run_off_q      <= run_off_d;
        first_align_q  <= first_align_d;
        expect_first_q <= expect_first_d;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_type_q  <= attr_i.component_type;
      in_count_q <= attr_i.component_count;
      in_final_q <= attr_i.final_attribute;
    end
    if (out_load) begin
      out_offset_q <= out_offset_d;
      out_bytes_q  <= out_bytes_d;
      out_stride_q <= out_stride_d;
      out_done_q   <= in_final_q;
      out_bad_q    <= out_bad_d;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.attribute_offset = out_offset_q;
  assign res_o.attribute_bytes  = out_bytes_q;
  assign res_o.vertex_stride    = out_stride_q;
  assign res_o.layout_done      = out_done_q;
  assign res_o.bad_count        = out_bad_q;

`ifndef SYNTHESIS
  // a closed format leaves clean layout state behind
  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && in_final_q |=> expect_first_q && (run_off_q == '0))
    else $error("layout state not cleared after final attribute");

  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expect_first_q |-> (run_off_q == '0) && (first_align_q == UNIT_ALIGN))
    else $error("stale layout state while awaiting first attribute");

  a_stride_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_done_q |-> (out_stride_q == '0))
    else $error("stride given on a non-final attribute");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_load |=> in_vld_q)
    else $error("pending attribute lost from input register");
`endif

endmodule
